// ===== rtl/frame_easing_interpolator_macros.svh =====
// ----------------------------------------------------------------------------
// Frame easing interpolator assertion macros
// Concurrent assertion wrappers; define NO_ASSERTIONS to compile them out.
// ----------------------------------------------------------------------------
`ifndef FRAME_EASING_INTERPOLATOR_MACROS_SVH
`define FRAME_EASING_INTERPOLATOR_MACROS_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, sampled on the rising clock edge
`define FEI_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication, sampled on the rising clock edge
`define FEI_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);
`else
`define FEI_ASSERT_IMP(lbl, ck, rn, ante, cons, msg)
`define FEI_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg)
`endif

`endif

// ===== rtl/fei_pkg.sv =====
// ----------------------------------------------------------------------------
// Frame easing interpolator package
// Widths, register indexes, curve mode codes and the curve mode decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package fei_pkg;

    // Field widths
    localparam int FRACTION_BITS_DEF = 16;
    localparam int VALUE_W           = 32;
    localparam int FRAME_W           = 32;
    localparam int DUR_W             = 16;
    localparam int MODE_W            = 4;
    localparam int CFG_IDX_W         = 3;
    localparam int CHANGE_W          = VALUE_W + 1;
    localparam int EXP_W             = 3;
    localparam int POW_STAGES        = 4;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FROM_VALUE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_VALUE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_START_FRAME  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DURATION     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CURVE_MODE   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_INTEGER_MODE = 3'd5;

    // Curve mode codes
    localparam logic [MODE_W-1:0] MODE_LINEAR      = 4'd0;
    localparam logic [MODE_W-1:0] MODE_QUAD_IN     = 4'd1;
    localparam logic [MODE_W-1:0] MODE_QUAD_OUT    = 4'd2;
    localparam logic [MODE_W-1:0] MODE_QUAD_INOUT  = 4'd3;
    localparam logic [MODE_W-1:0] MODE_CUBIC_IN    = 4'd4;
    localparam logic [MODE_W-1:0] MODE_CUBIC_OUT   = 4'd5;
    localparam logic [MODE_W-1:0] MODE_CUBIC_INOUT = 4'd6;
    localparam logic [MODE_W-1:0] MODE_QUART_IN    = 4'd7;
    localparam logic [MODE_W-1:0] MODE_QUART_OUT   = 4'd8;
    localparam logic [MODE_W-1:0] MODE_QUART_INOUT = 4'd9;
    localparam logic [MODE_W-1:0] MODE_QUINT_IN    = 4'd10;
    localparam logic [MODE_W-1:0] MODE_QUINT_OUT   = 4'd11;
    localparam logic [MODE_W-1:0] MODE_QUINT_INOUT = 4'd12;

    // Curve shape
    typedef enum logic [1:0] {
        KIND_LINEAR = 2'd0,
        KIND_IN     = 2'd1,
        KIND_OUT    = 2'd2,
        KIND_INOUT  = 2'd3
    } curve_kind_t;

    typedef struct packed {
        curve_kind_t            kind;
        logic [EXP_W-1:0]       exponent;
    } curve_dec_t;

    // Split a curve mode code into shape and power; unused codes act as linear
    function automatic curve_dec_t decode_mode(input logic [MODE_W-1:0] mode);
        curve_dec_t dec;
        dec.kind     = KIND_LINEAR;
        dec.exponent = 3'd1;
        unique case (mode) inside
            MODE_QUAD_IN, MODE_CUBIC_IN, MODE_QUART_IN, MODE_QUINT_IN:
                dec.kind = KIND_IN;
            MODE_QUAD_OUT, MODE_CUBIC_OUT, MODE_QUART_OUT, MODE_QUINT_OUT:
                dec.kind = KIND_OUT;
            MODE_QUAD_INOUT, MODE_CUBIC_INOUT, MODE_QUART_INOUT, MODE_QUINT_INOUT:
                dec.kind = KIND_INOUT;
            default:
                dec.kind = KIND_LINEAR;
        endcase
        unique case (mode) inside
            MODE_QUAD_IN, MODE_QUAD_OUT, MODE_QUAD_INOUT:
                dec.exponent = 3'd2;
            MODE_CUBIC_IN, MODE_CUBIC_OUT, MODE_CUBIC_INOUT:
                dec.exponent = 3'd3;
            MODE_QUART_IN, MODE_QUART_OUT, MODE_QUART_INOUT:
                dec.exponent = 3'd4;
            MODE_QUINT_IN, MODE_QUINT_OUT, MODE_QUINT_INOUT:
                dec.exponent = 3'd5;
            default:
                dec.exponent = 3'd1;
        endcase
        return dec;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/frame_easing_interpolator.sv =====
// ----------------------------------------------------------------------------
// Frame easing interpolator
// Eased value between two configured endpoints for a given frame number.
// ----------------------------------------------------------------------------
// Usage:
//   Configure through cfg_valid/cfg_index/cfg_data; cfg_ready is always high
//   and a transfer completes on every cycle with cfg_valid high. Indexes
//   above five are dropped. Write configuration only while no query is in
//   flight.
//   Issue a query by raising start with current_frame; busy stays low, so a
//   query is taken on every cycle that start is high (one per cycle).
//   The result appears on eased_value and finished for one cycle with
//   result_valid. A query passes the input and front registers, the ratio
//   divider, which resolves one quotient bit per stage, the base stage,
//   four power multiplier stages and the curve, scale, round, add, integer
//   and output stages.
//   The receiver cannot stall; every result must be taken when shown.
//   Reset clears all configuration registers to zero and drops every query
//   in flight.
// ----------------------------------------------------------------------------
`default_nettype none

`include "frame_easing_interpolator_macros.svh"

module frame_easing_interpolator #(
    parameter int FRACTION_BITS = fei_pkg::FRACTION_BITS_DEF
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 start,
    output logic                                      busy,
    input  wire logic [fei_pkg::FRAME_W-1:0]          current_frame,
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic [fei_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [fei_pkg::VALUE_W-1:0]          cfg_data,
    output logic                                      result_valid,
    output logic signed [fei_pkg::VALUE_W-1:0]        eased_value,
    output logic                                      finished
);

    localparam int F        = FRACTION_BITS;
    localparam int QB       = F + 1;
    localparam int VW       = fei_pkg::VALUE_W;
    localparam int DW       = fei_pkg::DUR_W;
    localparam int FW       = fei_pkg::FRAME_W;
    localparam int CW       = fei_pkg::CHANGE_W;
    localparam int EW       = fei_pkg::EXP_W;
    localparam int PS       = fei_pkg::POW_STAGES;
    localparam int PROD_W   = CW + QB;
    localparam int SUM_W    = VW + 3;
    localparam int RND_W    = SUM_W + 1;
    localparam int FE_TO_OUT = QB + 11;

    localparam logic [QB-1:0]     ONE  = {1'b1, {F{1'b0}}};
    localparam logic [QB-1:0]     HALF = {2'b01, {(F-1){1'b0}}};
    localparam logic [PROD_W-1:0] HALF_P = {{(PROD_W-F+1){1'b0}}, HALF[F-2:0]} | PROD_W'(HALF);
    localparam logic signed [RND_W-1:0] HALF_R    = RND_W'(HALF);
    localparam logic signed [RND_W-1:0] HALF_R_M1 = RND_W'(HALF) - RND_W'(1);
    localparam logic [RND_W-1:0]  FRAC_MASK = {{(RND_W-F){1'b0}}, {F{1'b1}}};
    localparam logic signed [RND_W-1:0] MAX_PLAIN = {{(RND_W-VW+1){1'b0}}, {(VW-1){1'b1}}};
    localparam logic signed [RND_W-1:0] MAX_INT   = MAX_PLAIN & ~FRAC_MASK;
    localparam logic signed [RND_W-1:0] MIN_VAL   = {{(RND_W-VW+1){1'b1}}, {(VW-1){1'b0}}};

    // ------------------------------------------------------------------
    // Configuration registers and values derived from them
    // ------------------------------------------------------------------
    logic signed [VW-1:0]              from_value_reg;
    logic signed [VW-1:0]              target_value_reg;
    logic [FW-1:0]                     start_frame_reg;
    logic [DW-1:0]                     duration_frames_reg;
    logic [fei_pkg::MODE_W-1:0]        curve_mode_reg;
    logic                              integer_mode_reg;
    logic [FW:0]                       end_frame_reg;
    logic [CW-1:0]                     chg_mag_reg;
    logic                              chg_neg_reg;
    logic signed [CW-1:0]              change;
    fei_pkg::curve_dec_t               mode_dec;

    assign cfg_ready = 1'b1;
    assign busy      = 1'b0;
    assign change    = {target_value_reg[VW-1], target_value_reg}
                     - {from_value_reg[VW-1], from_value_reg};
    assign mode_dec  = fei_pkg::decode_mode(curve_mode_reg);

    // Take configuration transfers; hold derived end frame and change magnitude
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            from_value_reg      <= '0;
            target_value_reg    <= '0;
            start_frame_reg     <= '0;
            duration_frames_reg <= '0;
            curve_mode_reg      <= fei_pkg::MODE_LINEAR;
            integer_mode_reg    <= 1'b0;
            end_frame_reg       <= '0;
            chg_mag_reg         <= '0;
            chg_neg_reg         <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    fei_pkg::REG_FROM_VALUE:   from_value_reg      <= cfg_data;
                    fei_pkg::REG_TARGET_VALUE: target_value_reg    <= cfg_data;
                    fei_pkg::REG_START_FRAME:  start_frame_reg     <= cfg_data;
                    fei_pkg::REG_DURATION:     duration_frames_reg <= cfg_data[DW-1:0];
                    fei_pkg::REG_CURVE_MODE:
                        curve_mode_reg <= cfg_data[fei_pkg::MODE_W-1:0];
                    fei_pkg::REG_INTEGER_MODE: integer_mode_reg    <= cfg_data[0];
                    default: ;
                endcase
            end
            end_frame_reg <= {1'b0, start_frame_reg} + {{(FW-DW+1){1'b0}}, duration_frames_reg};
            chg_neg_reg   <= change[CW-1];
            chg_mag_reg   <= change[CW-1] ? CW'(-change) : CW'(change);
        end
    end

    // ------------------------------------------------------------------
    // Valid chain
    // ------------------------------------------------------------------
    logic              in_valid_reg;
    logic              fe_valid_reg;
    logic              dv_valid_reg [QB];
    logic              bs_valid_reg;
    logic              pw_valid_reg [PS];
    logic              cv_valid_reg;
    logic              mu_valid_reg;
    logic              rd_valid_reg;
    logic              ad_valid_reg;
    logic              it_valid_reg;
    logic              result_valid_reg;

    // ------------------------------------------------------------------
    // Input register
    // ------------------------------------------------------------------
    logic [FW-1:0]     frame_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            frame_reg <= current_frame;
        end
    end

    // ------------------------------------------------------------------
    // Front stage: end test, bypass decision and elapsed frames
    // ------------------------------------------------------------------
    logic              fe_fin;
    logic              fe_byp;
    logic [FW-1:0]     fe_elapsed;
    logic              fe_fin_reg;
    logic              fe_byp_reg;
    logic [DW-1:0]     fe_elap_reg;

    assign fe_fin     = {1'b0, frame_reg} > end_frame_reg;
    assign fe_byp     = fe_fin || (duration_frames_reg == '0);
    assign fe_elapsed = (frame_reg > start_frame_reg) ? frame_reg - start_frame_reg : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fe_valid_reg <= 1'b0;
        end
        else
        begin
            fe_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        fe_fin_reg  <= fe_fin;
        fe_byp_reg  <= fe_byp;
        fe_elap_reg <= fe_elapsed[DW-1:0];
    end

    // ------------------------------------------------------------------
    // Ratio divider: one quotient bit per stage, most significant first
    // ------------------------------------------------------------------
    logic [DW-1:0]     dv_rem_reg [QB];
    logic [QB-1:0]     dv_q_reg   [QB];
    logic              dv_fin_reg [QB];
    logic              dv_byp_reg [QB];

    for (genvar k = 0; k < QB; k++)
    begin : g_div
        logic [DW:0]   rem_in;
        logic [DW:0]   rem_sub;
        logic [QB-1:0] q_in;
        logic          valid_in;
        logic          fin_in;
        logic          byp_in;
        logic          ge;

        if (k == 0)
        begin : g_first
            always_comb
            begin
                rem_in   = {1'b0, fe_elap_reg};
                q_in     = '0;
                valid_in = fe_valid_reg;
                fin_in   = fe_fin_reg;
                byp_in   = fe_byp_reg;
            end
        end
        else
        begin : g_rest
            always_comb
            begin
                rem_in   = {dv_rem_reg[k-1], 1'b0};
                q_in     = dv_q_reg[k-1];
                valid_in = dv_valid_reg[k-1];
                fin_in   = dv_fin_reg[k-1];
                byp_in   = dv_byp_reg[k-1];
            end
        end

        assign ge      = rem_in >= {1'b0, duration_frames_reg};
        assign rem_sub = rem_in - {1'b0, duration_frames_reg};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_valid_reg[k] <= 1'b0;
            end
            else
            begin
                dv_valid_reg[k] <= valid_in;
            end
        end

        // Subtract the divisor when it fits and shift the quotient bit in
        always_ff @(posedge clk)
        begin
            dv_rem_reg[k] <= ge ? rem_sub[DW-1:0] : rem_in[DW-1:0];
            dv_q_reg[k]   <= {q_in[QB-2:0], ge};
            dv_fin_reg[k] <= fin_in;
            dv_byp_reg[k] <= byp_in;
        end
    end

    // ------------------------------------------------------------------
    // Base stage: clamp ratio, pick the power base, latch the curve shape
    // ------------------------------------------------------------------
    logic [QB-1:0]         bs_r;
    logic [QB-1:0]         bs_s;
    logic                  bs_upper;
    logic [QB-1:0]         bs_r_reg;
    logic [QB-1:0]         bs_x_reg;
    logic                  bs_upper_reg;
    fei_pkg::curve_dec_t   bs_dec_reg;
    logic                  bs_fin_reg;
    logic                  bs_byp_reg;

    assign bs_r     = (dv_q_reg[QB-1] > ONE) ? ONE : dv_q_reg[QB-1];
    assign bs_s     = ONE - bs_r;
    assign bs_upper = bs_r >= HALF;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bs_valid_reg <= 1'b0;
        end
        else
        begin
            bs_valid_reg <= dv_valid_reg[QB-1];
        end
    end

    always_ff @(posedge clk)
    begin
        bs_r_reg     <= bs_r;
        bs_upper_reg <= bs_upper;
        bs_dec_reg   <= mode_dec;
        bs_fin_reg   <= dv_fin_reg[QB-1];
        bs_byp_reg   <= dv_byp_reg[QB-1];
        if ((mode_dec.kind == fei_pkg::KIND_OUT)
            || ((mode_dec.kind == fei_pkg::KIND_INOUT) && bs_upper))
        begin
            bs_x_reg <= bs_s;
        end
        else
        begin
            bs_x_reg <= bs_r;
        end
    end

    // ------------------------------------------------------------------
    // Power stages: at most one truncating fixed-point multiply per stage
    // ------------------------------------------------------------------
    logic [QB-1:0]         pw_acc_reg   [PS];
    logic [QB-1:0]         pw_x_reg     [PS];
    logic [QB-1:0]         pw_r_reg     [PS];
    logic                  pw_upper_reg [PS];
    fei_pkg::curve_dec_t   pw_dec_reg   [PS];
    logic                  pw_fin_reg   [PS];
    logic                  pw_byp_reg   [PS];

    for (genvar j = 0; j < PS; j++)
    begin : g_pow
        logic [QB-1:0]       acc_in;
        logic [QB-1:0]       x_in;
        logic [QB-1:0]       r_in;
        logic                upper_in;
        fei_pkg::curve_dec_t dec_in;
        logic                valid_in;
        logic                fin_in;
        logic                byp_in;
        logic [2*QB-1:0]     prod;

        if (j == 0)
        begin : g_first
            always_comb
            begin
                acc_in   = bs_x_reg;
                x_in     = bs_x_reg;
                r_in     = bs_r_reg;
                upper_in = bs_upper_reg;
                dec_in   = bs_dec_reg;
                valid_in = bs_valid_reg;
                fin_in   = bs_fin_reg;
                byp_in   = bs_byp_reg;
            end
        end
        else
        begin : g_rest
            always_comb
            begin
                acc_in   = pw_acc_reg[j-1];
                x_in     = pw_x_reg[j-1];
                r_in     = pw_r_reg[j-1];
                upper_in = pw_upper_reg[j-1];
                dec_in   = pw_dec_reg[j-1];
                valid_in = pw_valid_reg[j-1];
                fin_in   = pw_fin_reg[j-1];
                byp_in   = pw_byp_reg[j-1];
            end
        end

        assign prod = acc_in * x_in;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                pw_valid_reg[j] <= 1'b0;
            end
            else
            begin
                pw_valid_reg[j] <= valid_in;
            end
        end

        // Multiply while this stage is below the power, else pass through
        always_ff @(posedge clk)
        begin
            if (EW'(j + 1) < dec_in.exponent)
            begin
                pw_acc_reg[j] <= prod[F +: QB];
            end
            else
            begin
                pw_acc_reg[j] <= acc_in;
            end
            pw_x_reg[j]     <= x_in;
            pw_r_reg[j]     <= r_in;
            pw_upper_reg[j] <= upper_in;
            pw_dec_reg[j]   <= dec_in;
            pw_fin_reg[j]   <= fin_in;
            pw_byp_reg[j]   <= byp_in;
        end
    end

    // ------------------------------------------------------------------
    // Curve stage: fold the power into the selected shape
    // ------------------------------------------------------------------
    logic [QB-1:0]         cv_acc;
    logic [EW-1:0]         cv_shamt;
    logic [QB+EW:0]        cv_wide;
    logic [QB-1:0]         cv_shifted;
    logic [QB-1:0]         cv_c;
    logic [QB-1:0]         cv_c_reg;
    fei_pkg::curve_kind_t  cv_kind_reg;
    logic                  cv_upper_reg;
    logic                  cv_fin_reg;
    logic                  cv_byp_reg;

    assign cv_acc     = pw_acc_reg[PS-1];
    assign cv_shamt   = pw_dec_reg[PS-1].exponent - EW'(1);
    assign cv_wide    = {{(EW+1){1'b0}}, cv_acc} << cv_shamt;
    assign cv_shifted = cv_wide[QB-1:0];

    always_comb
    begin
        case (pw_dec_reg[PS-1].kind)
            fei_pkg::KIND_IN:    cv_c = cv_acc;
            fei_pkg::KIND_OUT:   cv_c = ONE - cv_acc;
            fei_pkg::KIND_INOUT: cv_c = pw_upper_reg[PS-1] ? ONE - cv_shifted : cv_shifted;
            default:             cv_c = pw_r_reg[PS-1];
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cv_valid_reg <= 1'b0;
        end
        else
        begin
            cv_valid_reg <= pw_valid_reg[PS-1];
        end
    end

    always_ff @(posedge clk)
    begin
        cv_c_reg     <= cv_c;
        cv_kind_reg  <= pw_dec_reg[PS-1].kind;
        cv_upper_reg <= pw_upper_reg[PS-1];
        cv_fin_reg   <= pw_fin_reg[PS-1];
        cv_byp_reg   <= pw_byp_reg[PS-1];
    end

    // ------------------------------------------------------------------
    // Scale stage: change magnitude times curve value
    // ------------------------------------------------------------------
    logic [PROD_W-1:0]     mu_prod_reg;
    logic                  mu_fin_reg;
    logic                  mu_byp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mu_valid_reg <= 1'b0;
        end
        else
        begin
            mu_valid_reg <= cv_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        mu_prod_reg <= PROD_W'(chg_mag_reg * cv_c_reg);
        mu_fin_reg  <= cv_fin_reg;
        mu_byp_reg  <= cv_byp_reg;
    end

    // ------------------------------------------------------------------
    // Round stage: product back to fixed point, half up on the magnitude
    // ------------------------------------------------------------------
    logic [PROD_W-1:0]     rd_sum;
    logic [CW-1:0]         rd_t_reg;
    logic                  rd_fin_reg;
    logic                  rd_byp_reg;

    assign rd_sum = mu_prod_reg + HALF_P;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= mu_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_t_reg   <= rd_sum[F +: CW];
        rd_fin_reg <= mu_fin_reg;
        rd_byp_reg <= mu_byp_reg;
    end

    // ------------------------------------------------------------------
    // Add stage: apply the signed term to the start value
    // ------------------------------------------------------------------
    logic signed [SUM_W-1:0] ad_from;
    logic signed [SUM_W-1:0] ad_t;
    logic signed [SUM_W-1:0] ad_val_reg;
    logic                    ad_fin_reg;
    logic                    ad_byp_reg;

    assign ad_from = {{(SUM_W-VW){from_value_reg[VW-1]}}, from_value_reg};
    assign ad_t    = {{(SUM_W-CW){1'b0}}, rd_t_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ad_valid_reg <= 1'b0;
        end
        else
        begin
            ad_valid_reg <= rd_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        ad_val_reg <= chg_neg_reg ? ad_from - ad_t : ad_from + ad_t;
        ad_fin_reg <= rd_fin_reg;
        ad_byp_reg <= rd_byp_reg;
    end

    // ------------------------------------------------------------------
    // Integer stage: round to a whole unit, half away from zero
    // ------------------------------------------------------------------
    logic signed [RND_W-1:0] it_ext;
    logic signed [RND_W-1:0] it_rnd;
    logic signed [RND_W-1:0] it_val_reg;
    logic                    it_int_reg;
    logic                    it_fin_reg;
    logic                    it_byp_reg;

    assign it_ext = {ad_val_reg[SUM_W-1], ad_val_reg};
    assign it_rnd = (it_ext + (it_ext[RND_W-1] ? HALF_R_M1 : HALF_R)) & ~FRAC_MASK;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            it_valid_reg <= 1'b0;
        end
        else
        begin
            it_valid_reg <= ad_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        it_val_reg <= integer_mode_reg ? it_rnd : it_ext;
        it_int_reg <= integer_mode_reg;
        it_fin_reg <= ad_fin_reg;
        it_byp_reg <= ad_byp_reg;
    end

    // ------------------------------------------------------------------
    // Output stage: saturate, or pass the target straight through
    // ------------------------------------------------------------------
    logic signed [RND_W-1:0] out_hi;
    logic signed [RND_W-1:0] out_sat;
    logic signed [VW-1:0]    eased_value_reg;
    logic                    finished_reg;
    logic                    out_int_reg;
    logic                    out_byp_reg;

    assign out_hi = it_int_reg ? MAX_INT : MAX_PLAIN;

    always_comb
    begin
        if (it_val_reg > out_hi)
        begin
            out_sat = out_hi;
        end
        else if (it_val_reg < MIN_VAL)
        begin
            out_sat = MIN_VAL;
        end
        else
        begin
            out_sat = it_val_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= it_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        eased_value_reg <= it_byp_reg ? target_value_reg : out_sat[VW-1:0];
        finished_reg    <= it_fin_reg;
        out_int_reg     <= it_int_reg;
        out_byp_reg     <= it_byp_reg;
    end

    assign result_valid = result_valid_reg;
    assign eased_value  = eased_value_reg;
    assign finished     = finished_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `FEI_ASSERT_IMP(a_curve_range, clk, rst_n, cv_valid_reg, cv_c_reg <= ONE,
        "curve value above one")
    `FEI_ASSERT_IMP(a_inout_split, clk, rst_n,
        cv_valid_reg && (cv_kind_reg == fei_pkg::KIND_INOUT),
        (cv_c_reg >= HALF) == cv_upper_reg, "in-out curve on wrong side of half")
    `FEI_ASSERT_IMP(a_valid_chain, clk, rst_n, result_valid_reg,
        $past(fe_valid_reg, FE_TO_OUT), "result without a matching query")
    `FEI_ASSERT_IMP(a_int_whole, clk, rst_n,
        result_valid_reg && out_int_reg && !out_byp_reg,
        eased_value_reg[F-1:0] == '0, "integer mode result has a fraction")

endmodule

`default_nettype wire

// ===== bench/frame_easing_interpolator_tb.sv =====
// ----------------------------------------------------------------------------
// Frame easing interpolator testbench
// Drives frame queries and register writes into the interpolator, predicts
// each eased value and finished flag in fixed point, and compares every
// result strobe against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module frame_easing_interpolator_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int     FRAME_W          = fei_pkg::FRAME_W;
    localparam int     VALUE_W          = fei_pkg::VALUE_W;
    localparam int     DUR_W            = fei_pkg::DUR_W;
    localparam int     MODE_W           = fei_pkg::MODE_W;
    localparam int     CFG_IDX_W        = fei_pkg::CFG_IDX_W;

    localparam int     CLK_PERIOD       = 10;
    localparam int     FRACTION_BITS    = fei_pkg::FRACTION_BITS_DEF;
    localparam int     LATENCY          = FRACTION_BITS + 14;
    localparam int     WATCHDOG_LIMIT   = 2000;
    localparam int     SHAPES_PER_POWER = 3;
    localparam int     RANDOM_PHASES    = 24;
    localparam int     FRAMES_PER_PHASE = 27;

    localparam longint unsigned ONE  = 64'd1 << FRACTION_BITS;
    localparam longint unsigned HALF = ONE >> 1;
    localparam longint INT_TOP   = longint'(64'h7FFF_FFFF & ~(ONE - 1));
    localparam longint VALUE_MAX = 64'sh7FFF_FFFF;
    localparam longint VALUE_MIN = -64'sh8000_0000;

    // Indexes past the last register; writes there must be dropped
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

    typedef struct {
        logic [CFG_IDX_W-1:0] index;
        logic [VALUE_W-1:0]   data;
    } reg_write_t;

    typedef struct {
        logic signed [VALUE_W-1:0] eased;
        logic                      finished;
    } eased_t;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      start = 1'b0;
    logic                      busy;
    logic [FRAME_W-1:0]        current_frame = '0;
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [CFG_IDX_W-1:0]      cfg_index = '0;
    logic [VALUE_W-1:0]        cfg_data = '0;
    logic                      result_valid;
    logic signed [VALUE_W-1:0] eased_value;
    logic                      finished;

    // Shadow copy of the configuration registers
    logic signed [VALUE_W-1:0] from_q = '0;
    logic signed [VALUE_W-1:0] target_q = '0;
    logic [FRAME_W-1:0]        start_frame_q = '0;
    logic [DUR_W-1:0]          duration_q = '0;
    logic [MODE_W-1:0]         curve_q = '0;
    logic                      integer_q = 1'b0;

    logic [FRAME_W-1:0] frames_todo[$];
    reg_write_t         reg_writes_todo[$];
    eased_t             eased_due[$];
    reg_write_t         next_write;
    eased_t             due_now;

    int frames_queued  = 0;
    int frames_sent    = 0;
    int regs_queued    = 0;
    int regs_written   = 0;
    int sender_idle_pct = 0;
    int failures       = 0;
    int stall_cycles   = 0;

    logic [FRAME_W-1:0] plan_start;
    logic [DUR_W-1:0]   plan_dur;

    frame_easing_interpolator #(
        .FRACTION_BITS (FRACTION_BITS)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .current_frame (current_frame),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .result_valid  (result_valid),
        .eased_value   (eased_value),
        .finished      (finished)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // x^p with a floor after every fixed point product
    function automatic longint unsigned fixed_pow(input longint unsigned x, input int p);
        longint unsigned acc;
        acc = x;
        for (int i = 1; i < p; i++)
            acc = (acc * x) >> FRACTION_BITS;
        return acc;
    endfunction

    // Curve value for ratio r under the current curve mode
    function automatic longint unsigned shape_of(input longint unsigned r);
        fei_pkg::curve_kind_t kind;
        int                   power;
        longint unsigned      rest;
        rest = ONE - r;
        if (curve_q == fei_pkg::MODE_LINEAR || curve_q > fei_pkg::MODE_QUINT_INOUT)
            return r;
        power = (int'(curve_q) - 1) / SHAPES_PER_POWER + 2;
        kind  = fei_pkg::curve_kind_t'((int'(curve_q) - 1) % SHAPES_PER_POWER + 1);
        case (kind)
            fei_pkg::KIND_IN:
                return fixed_pow(r, power);
            fei_pkg::KIND_OUT:
                return ONE - fixed_pow(rest, power);
            default:
            begin
                if (r < HALF)
                    return fixed_pow(r, power) << (power - 1);
                return ONE - (fixed_pow(rest, power) << (power - 1));
            end
        endcase
    endfunction

    // Expected eased value and finished flag for one frame query
    function automatic eased_t ease_frame(input logic [FRAME_W-1:0] frame);
        eased_t          res;
        longint unsigned end_frame;
        longint unsigned elapsed;
        longint unsigned ratio;
        longint unsigned mag;
        longint unsigned term;
        longint          change;
        longint          value;
        end_frame    = 64'(start_frame_q) + 64'(duration_q);
        res.finished = 64'(frame) > end_frame;
        if (res.finished || duration_q == '0)
        begin
            res.eased = target_q;
            return res;
        end
        elapsed = (frame > start_frame_q) ? 64'(frame) - 64'(start_frame_q) : 64'd0;
        ratio   = (elapsed << FRACTION_BITS) / 64'(duration_q);
        if (ratio > ONE)
            ratio = ONE;
        change = longint'(target_q) - longint'(from_q);
        if (change < 0)
            mag = -change;
        else
            mag = change;
        term = (mag * shape_of(ratio) + HALF) >> FRACTION_BITS;
        if (change < 0)
            value = longint'(from_q) - longint'(term);
        else
            value = longint'(from_q) + longint'(term);
        // Round to a whole number, half away from zero
        if (integer_q)
        begin
            if (value >= 0)
            begin
                mag   = value;
                mag   = ((mag + HALF) >> FRACTION_BITS) << FRACTION_BITS;
                value = longint'(mag);
            end
            else
            begin
                mag   = -value;
                mag   = ((mag + HALF) >> FRACTION_BITS) << FRACTION_BITS;
                value = -longint'(mag);
            end
            if (value > INT_TOP)
                value = INT_TOP;
        end
        if (value > VALUE_MAX)
            value = VALUE_MAX;
        if (value < VALUE_MIN)
            value = VALUE_MIN;
        res.eased = value[VALUE_W-1:0];
        return res;
    endfunction

    function automatic void latch_register(input logic [CFG_IDX_W-1:0] idx,
                                           input logic [VALUE_W-1:0] data);
        case (idx)
            fei_pkg::REG_FROM_VALUE:   from_q        = data;
            fei_pkg::REG_TARGET_VALUE: target_q      = data;
            fei_pkg::REG_START_FRAME:  start_frame_q = data;
            fei_pkg::REG_DURATION:     duration_q    = data[DUR_W-1:0];
            fei_pkg::REG_CURVE_MODE:   curve_q       = data[MODE_W-1:0];
            fei_pkg::REG_INTEGER_MODE: integer_q     = data[0];
            default:                   ;
        endcase
    endfunction

    // Query driver: predict on each transfer, then load the next frame
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start         <= 1'b0;
            current_frame <= '0;
        end
        else
        begin
            if (start && !busy)
            begin
                eased_due.push_back(ease_frame(current_frame));
                frames_sent++;
            end
            if (!start || !busy)
            begin
                if (frames_todo.size() != 0 && $urandom_range(99, 0) >= sender_idle_pct)
                begin
                    start         <= 1'b1;
                    current_frame <= frames_todo.pop_front();
                end
                else
                begin
                    start         <= 1'b0;
                    current_frame <= $urandom;
                end
            end
        end
    end

    // Register write driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_valid <= 1'b0;
            cfg_index <= '0;
            cfg_data  <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                latch_register(cfg_index, cfg_data);
                regs_written++;
            end
            if (!cfg_valid || cfg_ready)
            begin
                if (reg_writes_todo.size() != 0)
                begin
                    next_write = reg_writes_todo.pop_front();
                    cfg_valid <= 1'b1;
                    cfg_index <= next_write.index;
                    cfg_data  <= next_write.data;
                end
                else
                begin
                    cfg_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: compare against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && result_valid)
        begin
            if (eased_due.size() == 0)
            begin
                $error("result with nothing outstanding: eased_value %h finished %b",
                       eased_value, finished);
                failures++;
            end
            else
            begin
                due_now = eased_due.pop_front();
                if (eased_value !== due_now.eased)
                begin
                    $error("eased_value: expected %h, got %h", due_now.eased, eased_value);
                    failures++;
                end
                if (finished !== due_now.finished)
                begin
                    $error("finished: expected %b, got %b", due_now.finished, finished);
                    failures++;
                end
            end
        end
    end

    // Watchdog: end the run when no transfer happens for too long
    always @(posedge clk)
    begin
        if ((start && !busy) || result_valid || (cfg_valid && cfg_ready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("** frame_easing_interpolator: FAILED **");
            $finish;
        end
    end

    task automatic send_frame(input logic [FRAME_W-1:0] frame);
        frames_todo.push_back(frame);
        frames_queued++;
    endtask

    task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [VALUE_W-1:0] data);
        reg_writes_todo.push_back('{idx, data});
        regs_queued++;
    endtask

    // Hold until every query, write and result has gone through
    task automatic drain();
        do
            @(negedge clk);
        while (frames_sent != frames_queued || regs_written != regs_queued ||
               eased_due.size() != 0);
    endtask

    task automatic setup(input logic [VALUE_W-1:0] from_v, input logic [VALUE_W-1:0] target_v,
                         input logic [VALUE_W-1:0] start_v, input logic [VALUE_W-1:0] dur_v,
                         input logic [VALUE_W-1:0] mode_v, input logic [VALUE_W-1:0] int_v);
        drain();
        set_reg(fei_pkg::REG_FROM_VALUE, from_v);
        set_reg(fei_pkg::REG_TARGET_VALUE, target_v);
        set_reg(fei_pkg::REG_START_FRAME, start_v);
        set_reg(fei_pkg::REG_DURATION, dur_v);
        set_reg(fei_pkg::REG_CURVE_MODE, mode_v);
        set_reg(fei_pkg::REG_INTEGER_MODE, int_v);
        drain();
        plan_start = start_v;
        plan_dur   = dur_v[DUR_W-1:0];
    endtask

    function automatic logic [VALUE_W-1:0] pick_value();
        case ($urandom_range(5, 0))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return '0;
            3:       return $urandom << FRACTION_BITS;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [VALUE_W-1:0] pick_start();
        case ($urandom_range(3, 0))
            0:       return '0;
            1:       return 32'hFFFF_FFFF - $urandom_range(70000, 0);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [VALUE_W-1:0] pick_duration();
        case ($urandom_range(9, 0))
            0:       return '0;
            1:       return 32'h0000_FFFF;
            2:       return $urandom;
            default: return $urandom_range(64, 1);
        endcase
    endfunction

    // Mostly frames inside the transition window, some around it, some anywhere
    function automatic logic [FRAME_W-1:0] pick_frame();
        case ($urandom_range(9, 0))
            0:       return $urandom;
            1:       return plan_start - $urandom_range(3, 1);
            2:       return plan_start + plan_dur + $urandom_range(3, 1);
            default: return plan_start + $urandom_range(plan_dur, 0);
        endcase
    endfunction

    initial
    begin
        logic [MODE_W-1:0] mode_code;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Reset configuration: zero duration answers the target
        send_frame('0);
        send_frame(32'hFFFF_FFFF);

        // Full swing linear: before start, at start, middle, end, past end
        setup(32'h8000_0000, 32'h7FFF_FFFF, 32'd100, 32'd10,
              VALUE_W'(fei_pkg::MODE_LINEAR), 32'd0);
        send_frame('0);
        send_frame(32'd100);
        send_frame(32'd105);
        send_frame(32'd110);
        send_frame(32'd111);
        send_frame(32'hFFFF_FFFF);

        // Sweep every curve code, including the unused ones
        for (int m = 0; m < (1 << MODE_W); m++)
        begin
            mode_code = MODE_W'(m);
            if (!mode_code[0])
                setup(32'h8000_0000, 32'h7FFF_FFFF, 32'd100, 32'd10,
                      {{(VALUE_W-MODE_W){1'b0}}, mode_code}, VALUE_W'(mode_code[1]));
            else
                setup(32'h0003_8000, 32'hFFFE_4000, 32'd100, 32'd10,
                      {{(VALUE_W-MODE_W){1'b0}}, mode_code}, VALUE_W'(mode_code[1]));
            send_frame(32'd104 + 32'(m % 4));
        end

        // Window at the top of the frame range; end must not wrap
        setup(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0000_FFFF,
              VALUE_W'(fei_pkg::MODE_QUINT_INOUT), 32'd1);
        set_reg(REG_SPARE_A, 32'hFFFF_FFFF);
        set_reg(REG_SPARE_B, 32'h0000_0000);
        drain();
        send_frame(32'hFFFF_FFFF);
        send_frame('0);

        // Random phases: sender idles sometimes, then often, then never
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            if (phase < RANDOM_PHASES / 3)
                sender_idle_pct = 32;
            else if (phase < 2 * RANDOM_PHASES / 3)
                sender_idle_pct = 69;
            else
                sender_idle_pct = 0;
            drain();
            if ($urandom_range(3, 0) == 0)
                set_reg($urandom_range(1, 0) ? REG_SPARE_A : REG_SPARE_B, $urandom);
            setup(pick_value(), pick_value(), pick_start(), pick_duration(),
                  $urandom, $urandom);
            for (int n = 0; n < FRAMES_PER_PHASE; n++)
                send_frame(pick_frame());
        end

        drain();
        repeat (2 * LATENCY) @(posedge clk);
        if (failures == 0)
            $display("** frame_easing_interpolator: PASSED **");
        else
            $display("** frame_easing_interpolator: FAILED **");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/fei_pkg.sv
rtl/frame_easing_interpolator.sv
bench/frame_easing_interpolator_tb.sv
